### hw/rtl/multi_tap_detector_top_assert.svh
`ifndef MULTI_TAP_DETECTOR_TOP_ASSERT_SVH
`define MULTI_TAP_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mtd_pkg.sv
`default_nettype none

package mtd_pkg;

  typedef enum logic [1:0] {
    CFG_THRESHOLD     = 2'd0,
    CFG_WINDOW_US     = 2'd1,
    CFG_MIN_SPACING   = 2'd2,
    CFG_TAPS_REQUIRED = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] THRESHOLD_RST     = 16'd512;      // 2.0 g in 8.8
  localparam logic [31:0] WINDOW_US_RST     = 32'd2000000;
  localparam logic [31:0] MIN_SPACING_RST   = 32'd100000;
  localparam logic [2:0]  TAPS_REQUIRED_RST = 3'd3;

  typedef struct packed {
    logic [15:0] threshold;
    logic [31:0] window_us;
    logic [31:0] min_spacing_us;
    logic [2:0]  taps_required;
  } cfg_t;

  typedef struct packed {
    logic       detected;
    logic [2:0] tap_count;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/mtd_cfg_regs.sv
`default_nettype none

module mtd_cfg_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire mtd_pkg::cfg_idx_e cfg_index_i,
  input  wire logic [31:0]       cfg_data_i,
  output mtd_pkg::cfg_t          cfg_o
);
  import mtd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold      <= THRESHOLD_RST;
      cfg_q.window_us      <= WINDOW_US_RST;
      cfg_q.min_spacing_us <= MIN_SPACING_RST;
      cfg_q.taps_required  <= TAPS_REQUIRED_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD:     cfg_q.threshold      <= cfg_data_i[15:0];
        CFG_WINDOW_US:     cfg_q.window_us      <= cfg_data_i;
        CFG_MIN_SPACING:   cfg_q.min_spacing_us <= cfg_data_i;
        CFG_TAPS_REQUIRED: cfg_q.taps_required  <= cfg_data_i[2:0];
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/mtd_tap_core.sv
`default_nettype none

module mtd_tap_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire mtd_pkg::cfg_t cfg_i,
  input  wire logic [15:0]   magnitude_i,
  input  wire logic [31:0]   time_us_i,
  output mtd_pkg::res_t      res_o
);
  import mtd_pkg::*;

  logic [2:0]  count_q, count_d;
  logic [31:0] first_q, first_d;
  logic [31:0] last_q, last_d;
  logic        above_q, above_d;

  logic [31:0] since_first;
  logic [31:0] since_last;
  logic [2:0]  count_live;
  logic [2:0]  count_inc;
  logic        is_above;
  logic        new_tap;
  logic        hit;

  always_comb begin
    // modulo 2^32 differences
    since_first = time_us_i - first_q;
    since_last  = time_us_i - last_q;
    count_live  = ((count_q != 3'd0) && (since_first > cfg_i.window_us)) ? 3'd0 : count_q;
    is_above    = magnitude_i > cfg_i.threshold;
    new_tap     = is_above && !above_q &&
                  ((count_live == 3'd0) || (since_last >= cfg_i.min_spacing_us));
    count_inc   = count_live + 3'd1;
    // taps_required of zero acts as one: any counted tap hits
    hit         = new_tap && (count_inc >= cfg_i.taps_required);

    if (hit) begin
      count_d = 3'd0;
    end else if (new_tap) begin
      count_d = count_inc;
    end else begin
      count_d = count_live;
    end
    first_d = (new_tap && (count_live == 3'd0)) ? time_us_i : first_q;
    last_d  = new_tap ? time_us_i : last_q;
    above_d = is_above;

    res_o.detected  = hit;
    res_o.tap_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
      first_q <= 32'd0;
      last_q  <= 32'd0;
      above_q <= 1'b0;
    end else if (fire_i) begin
      count_q <= count_d;
      first_q <= first_d;
      last_q  <= last_d;
      above_q <= above_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/multi_tap_detector_top.sv
// Multi-tap detector: counts rising threshold crossings of an acceleration
// magnitude and flags a detection when taps_required taps fall inside the
// window with at least min_spacing_us between counted taps.
// Input channel: in_valid_i/in_ready_o with in_magnitude_i and in_time_us_i.
// Output channel: out_valid_o/out_ready_i with out_detected_o and
// out_tap_count_o; exactly one result per input request, in order.
// Config channel: cfg_valid_i/cfg_ready_o, cfg_index_i selects threshold,
// window_us, min_spacing_us or taps_required; cfg_ready_o is always high.
// Write config only while no request is in flight.
// A request accepted into the input register passes the tap logic and
// is registered in the result register, which drives the output.
// Throughput: one request per cycle while the receiver keeps up, set by a
// single input register and a single result register around the tap logic.
// When the receiver stalls, the result holds and the input register
// still takes one request; in_ready_o then drops until the output drains.
// Reset clears the tap state, the pipeline valids and loads the register
// defaults (2.0 g, 2000000 us, 100000 us, 3 taps).
`default_nettype none

module multi_tap_detector_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [15:0]       in_magnitude_i,
  input  wire logic [31:0]       in_time_us_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   out_detected_o,
  output logic [2:0]             out_tap_count_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire mtd_pkg::cfg_idx_e cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);
  import mtd_pkg::*;

  cfg_t        cfg;
  res_t        res;
  res_t        res_q;
  logic        in_valid_q;
  logic [15:0] mag_q;
  logic [31:0] time_q;
  logic        out_valid_q;
  logic        advance;
  logic        fire;

  assign advance     = !out_valid_q || out_ready_i;
  assign fire        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  mtd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mag_q  <= in_magnitude_i;
      time_q <= in_time_us_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  mtd_tap_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .cfg_i       (cfg),
    .magnitude_i (mag_q),
    .time_us_i   (time_q),
    .res_o       (res)
  );

  assign out_valid_o     = out_valid_q;
  assign out_detected_o  = res_q.detected;
  assign out_tap_count_o = res_q.tap_count;

endmodule

`default_nettype wire

### hw/rtl/mtd_checker.sv
`default_nettype none

`include "multi_tap_detector_top_assert.svh"

module mtd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        out_detected_o,
  input wire logic [2:0]  out_tap_count_o
);

  // a detection always restarts the sequence
  `MTD_ASSERT_NOW(a_hit_clears, out_valid_o && out_detected_o, out_tap_count_o == 3'd0, "detection with nonzero tap count")

  // an empty output side never blocks new requests
  `MTD_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o, "input stalled while output is empty")

  // a rising output valid always traces back to an accepted request
  `MTD_ASSERT_NOW(a_no_phantom, $rose(out_valid_o), $past(in_valid_i && in_ready_o, 2), "result without request")

  `MTD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_detected_o) && $stable(out_tap_count_o), "stalled result changed")

endmodule

bind multi_tap_detector_top mtd_checker u_mtd_checker (.*);

`default_nettype wire
